// ----- design/binary_to_decimal_digits_defines.svh -----
// Assertion macros for the checker file of binary_to_decimal_digits.
// No dependencies; include by bare file name.
`ifndef BINARY_TO_DECIMAL_DIGITS_DEFINES_SVH
`define BINARY_TO_DECIMAL_DIGITS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTD_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/btd_pkg.sv -----
// Types and constants for the binary to decimal digit converter.
// No dependencies.
`default_nettype none

package btd_pkg;

  localparam int unsigned HALF_BITS = 64;
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Input transaction: the value as two 64-bit halves.
  typedef struct packed {
    logic [HALF_BITS-1:0] value_high;
    logic [HALF_BITS-1:0] value_low;
  } in_data_t;

  // Output transaction: one ASCII digit and the end-of-run mark.
  typedef struct packed {
    logic [5:0] digit_char;
    logic       last_digit;
  } out_data_t;

  // Control of the BCD cell row, common to every cell.
  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // adjust-and-shift one binary bit in
    logic move;   // take the lower neighbor's digit
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_e;

endpackage

`default_nettype wire

// ----- design/btd_cell.sv -----
// One BCD digit cell of the converter row: clear, add-3 adjust and shift, or digit move.
// Depends on btd_pkg.
`default_nettype none

module btd_cell (
  input  wire logic              clk_i,
  input  wire btd_pkg::cell_ctrl_t ctrl_i,
  input  wire logic              carry_i,
  input  wire logic [3:0]        digit_i,
  output logic                   carry_o,
  output logic [3:0]             digit_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Add 3 to digits of 5 and above so the shift carries correctly.
  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[2:0], carry_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire

// ----- design/binary_to_decimal_digits.sv -----
// Top level of the binary to decimal digit converter: control FSM and BCD cell row.
// Depends on btd_pkg and btd_cell.
//
//  channel | direction | payload           | handshake
//  in      | input     | value_low/high    | in_valid_i / in_stall_o
//  out     | output    | digit_char, last  | out_valid_o / out_stall_i
//
// An item is accepted in ST_IDLE, shifted bit by bit through the cell row in
// ST_CONV, its leading zeros skipped in ST_SKIP, then its digits are emitted in
// ST_EMIT, one digit per cycle while the output does not stall.
// The binary shift loop through the cell row is the longest phase of an item.
// Reset clears the FSM, counters and output valid; the cells need no reset.
// Output stalls hold the digit register and pause the digit moves; the next
// item is taken while the final digit of a run still waits.
`default_nettype none

module binary_to_decimal_digits #(
  parameter int unsigned VALUE_BITS = 128
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire btd_pkg::in_data_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output btd_pkg::out_data_t      out_data_o
);

  // Decimal digits needed for 2**VALUE_BITS - 1.
  localparam int unsigned NDIG  = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int unsigned CNT_W = $clog2(VALUE_BITS);
  localparam int unsigned REM_W = $clog2(NDIG + 1);

  btd_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [REM_W-1:0]      rem_q, rem_d;
  logic [VALUE_BITS-1:0] bin_q, bin_d;
  logic                  out_valid_q, out_valid_d;
  btd_pkg::out_data_t    out_data_q, out_data_d;

  btd_pkg::cell_ctrl_t   cell_ctrl;
  logic                  in_accept;
  logic                  out_load;
  logic [2*btd_pkg::HALF_BITS-1:0] full_value;
  logic [3:0]            top_digit;

  logic [3:0] cell_digit [NDIG];
  logic       cell_carry [NDIG];

  // BCD cell row, cell 0 is the least significant digit.
  for (genvar i = 0; i < NDIG; i++) begin : g_cell
    if (i == 0) begin : g_first
      btd_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl),
        .carry_i (bin_q[VALUE_BITS-1]),
        .digit_i (4'd0),
        .carry_o (cell_carry[i]),
        .digit_o (cell_digit[i])
      );
    end else begin : g_rest
      btd_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (cell_ctrl),
        .carry_i (cell_carry[i-1]),
        .digit_i (cell_digit[i-1]),
        .carry_o (cell_carry[i]),
        .digit_o (cell_digit[i])
      );
    end
  end

  assign top_digit  = cell_digit[NDIG-1];
  assign full_value = {in_data_i.value_high, in_data_i.value_low};
  assign in_accept  = in_valid_i && (state_q == btd_pkg::ST_IDLE);
  assign out_load   = (state_q == btd_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      btd_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = btd_pkg::ST_CONV;
      end
      btd_pkg::ST_CONV: begin
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) state_d = btd_pkg::ST_SKIP;
      end
      btd_pkg::ST_SKIP: begin
        if (!((top_digit == 4'd0) && (rem_q > REM_W'(1)))) state_d = btd_pkg::ST_EMIT;
      end
      btd_pkg::ST_EMIT: begin
        if (out_load && (rem_q == REM_W'(1))) state_d = btd_pkg::ST_IDLE;
      end
      default: state_d = btd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the FSM: cell control, counters, shift register, output register
  always_comb begin
    cell_ctrl   = '0;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    bin_d       = bin_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      btd_pkg::ST_IDLE: begin
        if (in_accept) begin
          cell_ctrl.clear = 1'b1;
          cnt_d           = '0;
          bin_d           = full_value[VALUE_BITS-1:0];
        end
      end
      btd_pkg::ST_CONV: begin
        cell_ctrl.conv = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        bin_d          = {bin_q[VALUE_BITS-2:0], 1'b0};
        rem_d          = REM_W'(NDIG);
      end
      btd_pkg::ST_SKIP: begin
        if ((top_digit == 4'd0) && (rem_q > REM_W'(1))) begin
          cell_ctrl.move = 1'b1;
          rem_d          = rem_q - REM_W'(1);
        end
      end
      btd_pkg::ST_EMIT: begin
        if (out_load) begin
          cell_ctrl.move        = 1'b1;
          rem_d                 = rem_q - REM_W'(1);
          out_valid_d           = 1'b1;
          out_data_d.digit_char = btd_pkg::ASCII_ZERO + {2'b00, top_digit};
          out_data_d.last_digit = (rem_q == REM_W'(1));
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btd_pkg::ST_IDLE;
      cnt_q       <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    out_data_q <= out_data_d;
  end

  assign in_stall_o  = (state_q != btd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ----- design/btd_checker.sv -----
// Port-level assertions for binary_to_decimal_digits, bound to the top level.
// Depends on btd_pkg and binary_to_decimal_digits_defines.svh.
`default_nettype none
`include "binary_to_decimal_digits_defines.svh"

module btd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire btd_pkg::out_data_t out_data_o
);

  // A stalled output transaction holds.
  `BTD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled output changed")

  // Every digit shown is an ASCII decimal digit.
  `BTD_ASSERT_NOW(a_digit_range, clk_i, rst_ni, out_valid_o, (out_data_o.digit_char >= 6'd48) && (out_data_o.digit_char <= 6'd57), "digit out of range")

  // An accepted input starts a conversion that blocks further input.
  `BTD_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input taken during conversion")

  // Within a run the next digit follows right after a taken one.
  `BTD_ASSERT_NEXT(a_run_continues, clk_i, rst_ni, out_valid_o && !out_stall_i && !out_data_o.last_digit, out_valid_o, "gap inside a digit run")

endmodule

bind binary_to_decimal_digits btd_checker u_btd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
